### src/subchannel_q_sanity_checker_top_macros.svh
// ----------------------------------------------------------------------------
// Subchannel Q sanity checker assertion macros
// Assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SUBCHANNEL_Q_SANITY_CHECKER_TOP_MACROS_SVH
`define SUBCHANNEL_Q_SANITY_CHECKER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SCQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scq: assertion failed");
// next-cycle implication
`define SCQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scq: assertion failed");
`else
`define SCQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SCQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/scq_pkg.sv
// ----------------------------------------------------------------------------
// scq_pkg
// Shared types and constants of the subchannel Q sanity checker.
// ----------------------------------------------------------------------------
package scq_pkg;

   // sector counter width
   localparam int SectorIndexBits = 20;

   // record layout
   localparam int RecordBytes  = 12;
   localparam int RecordBits   = RecordBytes * 8;
   localparam int CrcBytes     = 10;
   localparam int ByteIdxBits  = $clog2(RecordBytes);
   localparam int RspDataBits  = 8;

   // position arithmetic
   localparam int PosBits   = 20;
   localparam int TrackBits = 7;
   localparam int DiffBits  = ((SectorIndexBits > PosBits) ? SectorIndexBits : PosBits) + 2;
   localparam int CfgBits   = 10;

   // constants of the Q format
   localparam logic [15:0] CrcPoly          = 16'h1021;
   localparam logic [3:0]  AdrPosition      = 4'h1;
   localparam logic [3:0]  BcdDigitMax      = 4'h9;
   localparam logic [7:0]  MaxSecondsBcd    = 8'h59;
   localparam logic [7:0]  MaxFramesBcd     = 8'h74;
   localparam int          SecondsPerMinute = 60;
   localparam int          FramesPerSecond  = 75;
   localparam int          AbsOffset        = 150;
   localparam logic [CfgBits-1:0] CfgReset  = CfgBits'(100);

   // queue between front and back
   localparam int QueueDepth     = 2;
   localparam int QueuePtrBits   = $clog2(QueueDepth);
   localparam int QueueCountBits = $clog2(QueueDepth + 1);

   // register index (from paddr[2])
   localparam logic RegMaxJump  = 1'b0;
   localparam logic RegMaxDrift = 1'b1;

   typedef enum logic [2:0] {
      ErrNone  = 3'd0,
      ErrBcd   = 3'd1,
      ErrJump  = 3'd2,
      ErrDrift = 3'd3,
      ErrTrack = 3'd4
   } err_type;

   // classified record
   typedef struct packed {
      logic                        used;
      logic                        bad;
      logic signed [PosBits-1:0]   pos;
      logic [TrackBits-1:0]        track;
      logic                        last;
   } entry_type;

   typedef struct packed {
      logic [CfgBits-1:0] max_jump;
      logic [CfgBits-1:0] max_drift;
   } cfg_type;

endpackage

### src/scq_front.sv
// ----------------------------------------------------------------------------
// scq_front
// Accepts a Q record, runs the CRC a byte per cycle and classifies it.
// ----------------------------------------------------------------------------
module scq_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [scq_pkg::RecordBits-1:0]  req_tdata,
   input  logic                            req_tlast,
   input  logic                            q_full,
   output logic                            q_push,
   output scq_pkg::entry_type              q_entry
);
   import scq_pkg::*;

   typedef enum logic [2:0] {
      FrIdle = 3'b001,
      FrCrc  = 3'b010,
      FrPush = 3'b100
   } front_state_type;

   localparam logic [ByteIdxBits-1:0] CrcLastByte = ByteIdxBits'(CrcBytes - 1);

   front_state_type        state_ff, state_in;
   logic [RecordBits-1:0]  rec_ff, rec_in;
   logic                   last_ff, last_in;
   logic [15:0]            crc_ff, crc_in;
   logic [ByteIdxBits-1:0] cnt_ff, cnt_in;
   logic [7:0]             q_byte [RecordBytes];

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic bcd_ok(input logic [7:0] v);
      return (v[3:0] <= BcdDigitMax) && (v[7:4] <= BcdDigitMax);
   endfunction

   function automatic logic [7:0] bcd_val(input logic [7:0] v);
      return 8'({4'h0, v[7:4]} * 8'd10) + {4'h0, v[3:0]};
   endfunction

   // record bytes: byte 0 at the top of q_first_eight, byte 8 at the top of q_last_four
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         q_byte[i] = rec_ff[63-8*i -: 8];
      end
      for (int i = 0; i < 4; i++) begin
         q_byte[8+i] = rec_ff[95-8*i -: 8];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      rec_in   = rec_ff;
      last_in  = last_ff;
      crc_in   = crc_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         FrIdle: begin
            if (req_tvalid) begin
               rec_in   = req_tdata;
               last_in  = req_tlast;
               crc_in   = '0;
               cnt_in   = '0;
               state_in = FrCrc;
            end
         end
         FrCrc: begin
            crc_in = crc_step(crc_ff, q_byte[cnt_ff]);
            cnt_in = cnt_ff + ByteIdxBits'(1);
            if (cnt_ff == CrcLastByte) state_in = FrPush;
         end
         FrPush: begin
            if (!q_full) state_in = FrIdle;
         end
         default: state_in = FrIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FrIdle;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      rec_ff  <= rec_in;
      last_ff <= last_in;
      crc_ff  <= crc_in;
   end

   // classification
   logic                 crc_ok;
   logic                 bcd_bad;
   logic                 range_bad;
   logic [6:0]           abs_m, abs_s, abs_f;
   logic [12:0]          seconds_total;
   logic [18:0]          frames_total;

   always_comb begin
      crc_ok  = (~crc_ff) == {q_byte[10], q_byte[11]};
      bcd_bad = 1'b0;
      for (int i = 1; i <= 9; i++) begin
         if (i != 6 && !bcd_ok(q_byte[i])) bcd_bad = 1'b1;
      end
      range_bad = (q_byte[4] > MaxSecondsBcd) || (q_byte[5] > MaxFramesBcd) ||
                  (q_byte[8] > MaxSecondsBcd) || (q_byte[9] > MaxFramesBcd);
      abs_m = 7'(bcd_val(q_byte[7]));
      abs_s = 7'(bcd_val(q_byte[8]));
      abs_f = 7'(bcd_val(q_byte[9]));
      seconds_total = 13'(abs_m) * 13'(SecondsPerMinute) + 13'(abs_s);
      frames_total  = 19'(seconds_total) * 19'(FramesPerSecond) + 19'(abs_f);

      q_entry.used  = crc_ok && (q_byte[0][3:0] == AdrPosition);
      q_entry.bad   = bcd_bad || range_bad;
      q_entry.pos   = PosBits'(frames_total) - PosBits'(AbsOffset);
      q_entry.track = TrackBits'(bcd_val(q_byte[1]));
      q_entry.last  = last_ff;
   end

   assign req_tready = (state_ff == FrIdle);
   assign q_push     = (state_ff == FrPush) && !q_full;

endmodule

### src/scq_queue.sv
// ----------------------------------------------------------------------------
// scq_queue
// Short queue of classified records between front and back.
// ----------------------------------------------------------------------------
module scq_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  scq_pkg::entry_type entry_in,
   output logic               full,
   input  logic               pop,
   output scq_pkg::entry_type entry_out,
   output logic               empty
);
   import scq_pkg::*;

   entry_type                 mem_ff [QueueDepth];
   logic [QueuePtrBits-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueCountBits-1:0] count_ff, count_in;

   assign full      = (count_ff == QueueCountBits'(QueueDepth));
   assign empty     = (count_ff == '0);
   assign entry_out = mem_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + QueueCountBits'(1);
      else if (pop && !push) count_in = count_ff - QueueCountBits'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QueuePtrBits'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QueuePtrBits'(1);
         count_ff <= count_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= entry_in;
   end

endmodule

### src/scq_back.sv
// ----------------------------------------------------------------------------
// scq_back
// Holds the run state, checks jump, drift and track, drives the result.
// ----------------------------------------------------------------------------
`include "subchannel_q_sanity_checker_top_macros.svh"
module scq_back (
   input  logic                             clock,
   input  logic                             reset,
   input  scq_pkg::cfg_type                 cfg,
   input  logic                             q_empty,
   input  scq_pkg::entry_type               q_entry,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [scq_pkg::RspDataBits-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);
   import scq_pkg::*;

   logic [SectorIndexBits-1:0] sidx_ff, sidx_in;
   logic                       have_prev_ff, have_prev_in;
   logic signed [PosBits-1:0]  prev_pos_ff, prev_pos_in;
   logic [TrackBits-1:0]       prev_track_ff, prev_track_in;
   err_type                    err_ff, err_in;

   logic                       rsp_valid_ff;
   err_type                    rsp_status_ff;
   logic                       rsp_used_ff;
   logic                       rsp_last_ff;

   logic [DiffBits-1:0]        pos_ext, prev_ext, sidx_ext;
   logic [DiffBits-1:0]        jump_diff, jump_abs, drift_diff, drift_abs;
   logic                       jump_big, drift_big;
   err_type                    err_eval;
   logic signed [PosBits-1:0]  prev_pos_eval;
   logic                       have_prev_eval;
   logic [TrackBits-1:0]       prev_track_eval;

   assign q_pop = !q_empty && (!rsp_valid_ff || rsp_tready);

   // distances
   always_comb begin
      pos_ext    = {{(DiffBits-PosBits){q_entry.pos[PosBits-1]}}, q_entry.pos};
      prev_ext   = {{(DiffBits-PosBits){prev_pos_ff[PosBits-1]}}, prev_pos_ff};
      sidx_ext   = {{(DiffBits-SectorIndexBits){1'b0}}, sidx_ff};
      jump_diff  = pos_ext - prev_ext;
      jump_abs   = jump_diff[DiffBits-1] ? (~jump_diff + DiffBits'(1)) : jump_diff;
      drift_diff = pos_ext - sidx_ext;
      drift_abs  = drift_diff[DiffBits-1] ? (~drift_diff + DiffBits'(1)) : drift_diff;
      jump_big   = jump_abs > DiffBits'(cfg.max_jump);
      drift_big  = drift_abs > DiffBits'(cfg.max_drift);
   end

   // checks in priority order, first error sticks
   always_comb begin
      err_eval        = err_ff;
      prev_pos_eval   = prev_pos_ff;
      have_prev_eval  = have_prev_ff;
      prev_track_eval = prev_track_ff;
      if (q_entry.used && err_ff == ErrNone) begin
         if (q_entry.bad) begin
            err_eval = ErrBcd;
         end else if (have_prev_ff && jump_big) begin
            err_eval = ErrJump;
         end else if (drift_big) begin
            err_eval = ErrDrift;
         end else begin
            prev_pos_eval  = q_entry.pos;
            have_prev_eval = 1'b1;
            if (q_entry.track < prev_track_ff) err_eval = ErrTrack;
            else prev_track_eval = q_entry.track;
         end
      end
   end

   // commit, or clear at the end of a run
   always_comb begin
      sidx_in       = sidx_ff;
      have_prev_in  = have_prev_ff;
      prev_pos_in   = prev_pos_ff;
      prev_track_in = prev_track_ff;
      err_in        = err_ff;
      if (q_pop) begin
         if (q_entry.last) begin
            sidx_in       = '0;
            have_prev_in  = 1'b0;
            prev_pos_in   = '0;
            prev_track_in = '0;
            err_in        = ErrNone;
         end else begin
            sidx_in       = sidx_ff + SectorIndexBits'(1);
            have_prev_in  = have_prev_eval;
            prev_pos_in   = prev_pos_eval;
            prev_track_in = prev_track_eval;
            err_in        = err_eval;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sidx_ff       <= '0;
         have_prev_ff  <= 1'b0;
         prev_pos_ff   <= '0;
         prev_track_ff <= '0;
         err_ff        <= ErrNone;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sidx_ff       <= sidx_in;
         have_prev_ff  <= have_prev_in;
         prev_pos_ff   <= prev_pos_in;
         prev_track_ff <= prev_track_in;
         err_ff        <= err_in;
         if (q_pop) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (q_pop) begin
         rsp_status_ff <= err_eval;
         rsp_used_ff   <= q_entry.used;
         rsp_last_ff   <= q_entry.last;
      end
   end

   // result register
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataBits-4){1'b0}}, rsp_used_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `SCQ_ASSERT_NEXT(a_err_sticky, clock, reset, (err_ff != ErrNone) && !(q_pop && q_entry.last), err_ff == $past(err_ff))
   `SCQ_ASSERT_NEXT(a_run_clears, clock, reset, q_pop && q_entry.last, (sidx_ff == '0) && !have_prev_ff && (err_ff == ErrNone))
   `SCQ_ASSERT_IMPLY(a_prev_unset, clock, reset, !have_prev_ff, prev_pos_ff == '0)

endmodule

### src/subchannel_q_sanity_checker_top.sv
// The front end takes one request at a time: it accepts a new request only once the
// byte-serial CRC unit has run (one CRC byte per cycle over ten bytes) and the record
// has been pushed into the queue, which it waits for while the queue is full.
// Reset: synchronous, active high; clears run state, queue and result register,
// and sets max_jump and max_drift back to 100.
// ----------------------------------------------------------------------------
// subchannel_q_sanity_checker_top
// Checks the Q subchannel of each sector for CRC, BCD, position and track sanity.
// ----------------------------------------------------------------------------
module subchannel_q_sanity_checker_top (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata = q_first_eight [63:0], q_last_four [95:64]; tlast = last_sector
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [scq_pkg::RecordBits-1:0]  req_tdata,
   input  logic                            req_tlast,
   // result: tdata = status [2:0], record_used [3], zeros above; tlast = run_done
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [scq_pkg::RspDataBits-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // configuration: max_jump at 0x0, max_drift at 0x4
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [2:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import scq_pkg::*;

   cfg_type   cfg_ff;
   logic      cfg_we;
   logic      q_full, q_empty, q_push, q_pop;
   entry_type push_entry, pop_entry;

   // register file
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_jump  <= CfgReset;
         cfg_ff.max_drift <= CfgReset;
      end else if (cfg_we) begin
         case (csr_paddr[2])
            RegMaxJump:  cfg_ff.max_jump  <= csr_pwdata[CfgBits-1:0];
            RegMaxDrift: cfg_ff.max_drift <= csr_pwdata[CfgBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         RegMaxJump:  csr_prdata = {{(32-CfgBits){1'b0}}, cfg_ff.max_jump};
         RegMaxDrift: csr_prdata = {{(32-CfgBits){1'b0}}, cfg_ff.max_drift};
         default:     csr_prdata = '0;
      endcase
   end

   scq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   scq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .entry_in  (push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .entry_out (pop_entry),
      .empty     (q_empty)
   );

   scq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### tb/tb_subchannel_q_sanity_checker_top.sv
// ----------------------------------------------------------------------------
// Subchannel Q sanity checker testbench
// Drives Q records through the request stream and checks every status result
// against a behavioural predictor of the checker or a typed row's verdict. A
// directed table covers the field extremes and each kind of error. Random runs
// of mostly well-formed sectors follow, with broken CRCs, foreign ADR values,
// bad BCD, position jumps and falling tracks mixed in. Limit settings change
// between phases, and back-pressure and request gaps vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_subchannel_q_sanity_checker_top;
   timeunit 1ns;
   timeprecision 1ps;

   import scq_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 16;
   localparam int ItemsPerPhase = 171;
   localparam int PhaseCount = 6;
   localparam int MaxPosition = 449849;
   localparam logic [2:0] AddrMaxJump  = {RegMaxJump, 2'b00};
   localparam logic [2:0] AddrMaxDrift = {RegMaxDrift, 2'b00};

   // twelve Q bytes, entry i is record byte i
   typedef logic [RecordBytes-1:0][7:0] qbytes_type;

   typedef struct packed {
      err_type status;
      logic    used;
      logic    done;
   } q_verdict_type;

   typedef struct {
      logic [RecordBits-1:0] data;
      logic                  last;
      logic                  typed;
      q_verdict_type         want;
   } table_row_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   // fields from bit 0: q_first_eight [63:0], q_last_four [95:64]
   logic [RecordBits-1:0]   req_tdata;
   logic                    req_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // fields from bit 0: status [2:0], record_used [3], zeros above
   logic [RspDataBits-1:0]  rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [2:0]              csr_paddr;
   logic [31:0]             csr_pwdata;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   // predictor state
   logic [SectorIndexBits-1:0] chk_sector;
   logic                       chk_have_prev;
   int                         chk_prev_pos;
   int                         chk_prev_track;
   err_type                    chk_error;
   logic [CfgBits-1:0]         lim_jump;
   logic [CfgBits-1:0]         lim_drift;

   q_verdict_type verdict_q[$];
   table_row_type sector_table[$];
   int            mismatches = 0;
   int            cycles = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;

   subchannel_q_sanity_checker_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH @%0d: %s", cycles, msg);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // record construction
   // ------------------------------------------------------------------
   function automatic logic [7:0] to_bcd(input int v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic int bcd_num(input logic [7:0] v);
      return int'(v[7:4]) * 10 + int'(v[3:0]);
   endfunction

   // CRC-16/0x1021, zero start, MSB first over bytes 0..9
   function automatic logic [15:0] q_crc(input qbytes_type b);
      logic [15:0] c;
      int          i;
      int          k;
      c = '0;
      for (i = 0; i < CrcBytes; i++) begin
         c ^= {b[i], 8'h00};
         for (k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

   function automatic qbytes_type seal(input qbytes_type b);
      logic [15:0] c;
      c = ~q_crc(b);
      b[10] = c[15:8];
      b[11] = c[7:0];
      return b;
   endfunction

   // byte 0 lands in tdata[63:56], byte 8 in tdata[95:88]
   function automatic logic [RecordBits-1:0] pack_q(input qbytes_type b);
      logic [RecordBits-1:0] d;
      int                    i;
      d = '0;
      for (i = 0; i < 8; i++)
         d[63 - 8 * i -: 8] = b[i];
      for (i = 0; i < 4; i++)
         d[95 - 8 * i -: 8] = b[8 + i];
      return d;
   endfunction

   function automatic qbytes_type unpack_q(input logic [RecordBits-1:0] d);
      qbytes_type b;
      int         i;
      for (i = 0; i < 8; i++)
         b[i] = d[63 - 8 * i -: 8];
      for (i = 0; i < 4; i++)
         b[8 + i] = d[95 - 8 * i -: 8];
      return b;
   endfunction

   function automatic int clamp_pos(input int p);
      if (p < -AbsOffset)
         return -AbsOffset;
      if (p > MaxPosition)
         return MaxPosition;
      return p;
   endfunction

   // well-formed ADR 1 record with sealed CRC; unchecked bytes are random
   function automatic qbytes_type good_record(input int track, input int pos);
      qbytes_type b;
      int         p;
      p = pos + AbsOffset;
      b[0] = {4'($urandom_range(15)), AdrPosition};
      b[1] = to_bcd(track);
      b[2] = to_bcd($urandom_range(99));
      b[3] = to_bcd($urandom_range(99));
      b[4] = to_bcd($urandom_range(59));
      b[5] = to_bcd($urandom_range(74));
      b[6] = 8'($urandom_range(255));
      b[7] = to_bcd(p / (SecondsPerMinute * FramesPerSecond));
      b[8] = to_bcd((p / FramesPerSecond) % SecondsPerMinute);
      b[9] = to_bcd(p % FramesPerSecond);
      return seal(b);
   endfunction

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic int abs_diff(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic void clear_run();
      chk_sector     = '0;
      chk_have_prev  = 1'b0;
      chk_prev_pos   = 0;
      chk_prev_track = 0;
      chk_error      = ErrNone;
   endfunction

   function automatic q_verdict_type predict_q(input logic [RecordBits-1:0] d, input logic last);
      qbytes_type    b;
      logic [15:0]   c;
      logic          used;
      logic          bad;
      int            i;
      int            pos;
      int            track;
      q_verdict_type v;
      b = unpack_q(d);
      c = ~q_crc(b);
      used = (c == {b[10], b[11]}) && (b[0][3:0] == AdrPosition);
      if (used && chk_error == ErrNone) begin
         bad = 1'b0;
         for (i = 1; i <= 9; i++)
            if (i != 6 && (b[i][3:0] > BcdDigitMax || b[i][7:4] > BcdDigitMax))
               bad = 1'b1;
         if (b[4] > MaxSecondsBcd || b[5] > MaxFramesBcd || b[8] > MaxSecondsBcd ||
             b[9] > MaxFramesBcd)
            bad = 1'b1;
         if (bad) begin
            chk_error = ErrBcd;
         end else begin
            pos = (bcd_num(b[7]) * SecondsPerMinute + bcd_num(b[8])) * FramesPerSecond
                  + bcd_num(b[9]) - AbsOffset;
            track = bcd_num(b[1]);
            if (chk_have_prev && abs_diff(pos, chk_prev_pos) > int'(lim_jump)) begin
               chk_error = ErrJump;
            end else if (abs_diff(pos, int'(chk_sector)) > int'(lim_drift)) begin
               chk_error = ErrDrift;
            end else begin
               chk_prev_pos  = pos;
               chk_have_prev = 1'b1;
               if (track < chk_prev_track)
                  chk_error = ErrTrack;
               else
                  chk_prev_track = track;
            end
         end
      end
      v.status = chk_error;
      v.used   = used;
      v.done   = last;
      if (last)
         clear_run();
      else
         chk_sector = chk_sector + 1'b1;
      return v;
   endfunction

   function automatic q_verdict_type verdict(input err_type s, input logic u, input logic d);
      q_verdict_type v;
      v.status = s;
      v.used   = u;
      v.done   = d;
      return v;
   endfunction

   // ------------------------------------------------------------------
   // drivers, called at the falling edge
   // ------------------------------------------------------------------
   task automatic send_request(input logic [RecordBits-1:0] data, input logic last,
                               input logic typed, input q_verdict_type want);
      q_verdict_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pred = predict_q(data, last);
      verdict_q.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input int unsigned value);
      logic [31:0] got;
      logic [31:0] held;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      if (wr) begin
         if (addr == AddrMaxJump)
            lim_jump = CfgBits'(value);
         else
            lim_drift = CfgBits'(value);
      end else begin
         held = (addr == AddrMaxJump) ? 32'(lim_jump) : 32'(lim_drift);
         if (got !== held)
            flag_mismatch($sformatf("register at 0x%0h reads %0d, want %0d", addr, got, held));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_limits(input int unsigned jump, input int unsigned drift);
      csr_access(1'b1, AddrMaxJump, jump);
      csr_access(1'b1, AddrMaxDrift, drift);
      csr_access(1'b0, AddrMaxJump, 0);
      csr_access(1'b0, AddrMaxDrift, 0);
   endtask

   // drop valid and let every outstanding result come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // one run of sectors ending on a last-sector request; mostly sane records
   task automatic play_run(input int len);
      int         bias;
      int         track;
      int         pos;
      int         kind;
      int         k;
      int         pick;
      qbytes_type b;
      logic [RecordBits-1:0] d;
      bias  = ($urandom_range(9) < 7) ? 0 : int'($urandom_range(40)) - 20;
      track = $urandom_range(1, 90);
      for (k = 0; k < len; k++) begin
         pos = k + bias;
         if ($urandom_range(9) == 0)
            pos += int'($urandom_range(2)) - 1;
         if ($urandom_range(19) == 0 && track < 99)
            track++;
         b = good_record(track, clamp_pos(pos));
         kind = $urandom_range(99);
         if (kind >= 70 && kind < 78) begin
            // broken CRC
            pick = $urandom_range(RecordBytes - 1);
            b[pick] = b[pick] ^ 8'(1 << $urandom_range(7));
         end else if (kind >= 78 && kind < 83) begin
            // foreign ADR
            pick = $urandom_range(15);
            b[0][3:0] = (4'(pick) == AdrPosition) ? 4'h0 : 4'(pick);
            b = seal(b);
         end else if (kind >= 83 && kind < 88) begin
            // arbitrary value in one of bytes 1 to 9
            pick = $urandom_range(1, 9);
            b[pick] = 8'($urandom_range(255));
            b = seal(b);
         end else if (kind >= 88 && kind < 92) begin
            pick = $urandom_range(1, 1100);
            b = good_record(track, clamp_pos($urandom_range(1) ? pos + pick : pos - pick));
         end else if (kind >= 92 && kind < 95 && track > 0) begin
            b = good_record($urandom_range(track - 1), clamp_pos(pos));
         end
         d = (kind >= 95) ? {$urandom, $urandom, $urandom} : pack_q(b);
         send_request(d, k == len - 1, 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------
   task automatic check_result();
      q_verdict_type want;
      if (verdict_q.size() == 0) begin
         flag_mismatch($sformatf("result 0x%0h with no request pending", rsp_tdata));
      end else begin
         want = verdict_q.pop_front();
         if (rsp_tdata[2:0] !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", rsp_tdata[2:0], want.status));
         if (rsp_tdata[3] !== want.used)
            flag_mismatch($sformatf("record_used %b, want %b", rsp_tdata[3], want.used));
         if (rsp_tlast !== want.done)
            flag_mismatch($sformatf("run_done %b, want %b", rsp_tlast, want.done));
         if (rsp_tdata[RspDataBits-1:4] !== '0)
            flag_mismatch($sformatf("padding bits 0x%0h", rsp_tdata[RspDataBits-1:4]));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_result();
   end

   // receiver back-pressure
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // ------------------------------------------------------------------
   // directed table
   // ------------------------------------------------------------------
   task automatic add_row(input qbytes_type b, input logic last, input logic typed,
                          input q_verdict_type want);
      table_row_type r;
      r.data  = pack_q(b);
      r.last  = last;
      r.typed = typed;
      r.want  = want;
      sector_table.push_back(r);
   endtask

   task automatic build_table();
      qbytes_type b;
      // run with skipped records and a BCD error that sticks
      add_row(good_record(1, 0), 1'b0, 1'b1, verdict(ErrNone, 1'b1, 1'b0));
      add_row(good_record(1, 1), 1'b0, 1'b1, verdict(ErrNone, 1'b1, 1'b0));
      b = good_record(1, 2);
      b[10] = b[10] ^ 8'h01;
      add_row(b, 1'b0, 1'b1, verdict(ErrNone, 1'b0, 1'b0));
      b = good_record(1, 3);
      b[0][3:0] = 4'h2;
      add_row(seal(b), 1'b0, 1'b1, verdict(ErrNone, 1'b0, 1'b0));
      add_row(good_record(2, 4), 1'b0, 1'b0, '0);
      b = good_record(2, 5);
      b[2] = 8'h0A;
      add_row(seal(b), 1'b0, 1'b1, verdict(ErrBcd, 1'b1, 1'b0));
      add_row(good_record(3, 6), 1'b1, 1'b1, verdict(ErrBcd, 1'b1, 1'b1));
      // falling track
      add_row(good_record(99, 0), 1'b0, 1'b1, verdict(ErrNone, 1'b1, 1'b0));
      add_row(good_record(98, 1), 1'b1, 1'b1, verdict(ErrTrack, 1'b1, 1'b1));
      // drift at the limit, then a jump just over it
      add_row(good_record(0, 100), 1'b0, 1'b0, '0);
      add_row(good_record(0, 201), 1'b1, 1'b1, verdict(ErrJump, 1'b1, 1'b1));
      // drift just over the limit, then an all-zero record
      add_row(good_record(0, 101), 1'b0, 1'b1, verdict(ErrDrift, 1'b1, 1'b0));
      add_row('0, 1'b1, 1'b1, verdict(ErrDrift, 1'b0, 1'b1));
      // highest absolute time, then an all-ones record
      add_row(good_record(1, MaxPosition), 1'b0, 1'b0, '0);
      add_row('1, 1'b1, 1'b0, '0);
      // lowest absolute time
      add_row(good_record(1, -AbsOffset), 1'b1, 1'b1, verdict(ErrDrift, 1'b1, 1'b1));
      // seconds and frames out of range, bad digits
      b = good_record(1, 0);
      b[4] = 8'h60;
      add_row(seal(b), 1'b1, 1'b1, verdict(ErrBcd, 1'b1, 1'b1));
      b = good_record(1, 0);
      b[5] = 8'h75;
      add_row(seal(b), 1'b1, 1'b1, verdict(ErrBcd, 1'b1, 1'b1));
      b = good_record(1, 0);
      b[8] = 8'h60;
      add_row(seal(b), 1'b1, 1'b1, verdict(ErrBcd, 1'b1, 1'b1));
      b = good_record(1, 0);
      b[9] = 8'h75;
      add_row(seal(b), 1'b1, 1'b1, verdict(ErrBcd, 1'b1, 1'b1));
      b = good_record(1, 0);
      b[1] = 8'hA0;
      add_row(seal(b), 1'b1, 1'b1, verdict(ErrBcd, 1'b1, 1'b1));
      b = good_record(1, 0);
      b[7] = 8'h9F;
      add_row(seal(b), 1'b1, 1'b1, verdict(ErrBcd, 1'b1, 1'b1));
      // byte 6 is not checked
      b = good_record(1, 0);
      b[6] = 8'hFF;
      add_row(seal(b), 1'b1, 1'b1, verdict(ErrNone, 1'b1, 1'b1));
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned jump_set[PhaseCount];
      int unsigned drift_set[PhaseCount];
      int          phase;
      int          sent;
      int          len;
      int          i;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      lim_jump    = CfgReset;
      lim_drift   = CfgReset;
      clear_run();
      jump_set  = '{0, 1023, $urandom_range(1023), 3, 1023, 100};
      drift_set = '{0, 1023, $urandom_range(1023), 1023, 2, 100};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // limits after reset
      csr_access(1'b0, AddrMaxJump, 0);
      csr_access(1'b0, AddrMaxDrift, 0);

      send_idle_pct = 38;
      recv_idle_pct = 59;
      build_table();
      for (i = 0; i < sector_table.size(); i++)
         send_request(sector_table[i].data, sector_table[i].last, sector_table[i].typed,
                      sector_table[i].want);
      wait_idle();

      for (phase = 0; phase < PhaseCount; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 59;
            recv_idle_pct = 38;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_limits(jump_set[phase], drift_set[phase]);
         sent = 0;
         while (sent < ItemsPerPhase) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
            play_run(len);
            sent += len;
         end
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
